FILE: sv/accel_dead_reckoning_zero_velocity_macros.svh
// assertion macros for the dead reckoning block
// no dependencies; included by the top level only
`ifndef ACCEL_DEAD_RECKONING_ZERO_VELOCITY_MACROS_SVH
`define ACCEL_DEAD_RECKONING_ZERO_VELOCITY_MACROS_SVH

// same-cycle implication
`define DRZV_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DRZV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/drzv_pkg.sv
// shared types and constants for the dead reckoning block
// no dependencies; imported by every module of the block
package drzv_pkg;

   localparam int ACCEL_W  = 16;
   localparam int THR_W    = 16;
   localparam int CNT_W    = 8;
   localparam int VEL_W    = 40;
   localparam int POS_W    = 56;
   localparam int CSR_AW   = 5;
   localparam int CSR_DW   = 32;
   localparam int NUM_AXES = 3;

   localparam logic [THR_W-1:0] THR_RESET = THR_W'(410);
   localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(5);
   localparam logic [CNT_W-1:0] RUN_MAX   = {CNT_W{1'b1}};

   typedef enum logic [2:0] {
      REG_BIAS_X          = 3'd0,
      REG_BIAS_Y          = 3'd1,
      REG_BIAS_Z          = 3'd2,
      REG_STILL_THRESHOLD = 3'd3,
      REG_STILL_COUNT     = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic signed [ACCEL_W-1:0] accel_x;
      logic signed [ACCEL_W-1:0] accel_y;
      logic signed [ACCEL_W-1:0] accel_z;
   } req_payload_type;

   typedef struct packed {
      logic signed [VEL_W-1:0] vel_x;
      logic signed [VEL_W-1:0] vel_y;
      logic signed [VEL_W-1:0] vel_z;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic [NUM_AXES-1:0]     still_flags;
   } rsp_payload_type;

   typedef struct packed {
      logic signed [ACCEL_W-1:0] bias_x;
      logic signed [ACCEL_W-1:0] bias_y;
      logic signed [ACCEL_W-1:0] bias_z;
      logic [THR_W-1:0]          still_threshold;
      logic [CNT_W-1:0]          still_count;
   } cfg_type;

   typedef struct packed {
      logic s1_load;
      logic s2_load;
      logic s3_load;
      logic s2_valid;
   } pipe_ctrl_type;

endpackage

FILE: sv/drzv_lane.sv
// one axis lane: bias subtract and window check, velocity and run update,
// saturating position update; three stages. depends on drzv_pkg
module drzv_lane import drzv_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  pipe_ctrl_type             ctrl,
   input  logic signed [ACCEL_W-1:0] accel,
   input  logic signed [ACCEL_W-1:0] bias,
   input  logic [THR_W-1:0]          thr,
   input  logic [CNT_W-1:0]          cnt,
   output logic signed [VEL_W-1:0]   vel,
   output logic signed [POS_W-1:0]   pos,
   output logic                      flag
);

   localparam int DIFF_W = ACCEL_W + 1;
   localparam int SUM_W  = ((VEL_W > POS_W) ? VEL_W : POS_W) + 1;

   // stage 1
   logic signed [DIFF_W-1:0] diff_in, diff_ff;
   logic signed [DIFF_W:0]   diff_ext, thr_ext;
   logic                     win_in, win_ff;

   // stage 2
   logic signed [VEL_W:0]    vsum_wide;
   logic signed [VEL_W-1:0]  vsum;
   logic signed [VEL_W-1:0]  vel_in, vel_ff, vout_ff, vsum_ff;
   logic [CNT_W-1:0]         run_in, run_ff;
   logic                     clear;
   logic                     flag2_ff;

   // stage 3
   logic signed [SUM_W-1:0]  psum, hi_lim, lo_lim;
   logic signed [POS_W-1:0]  pos_in, pos_ff;
   logic signed [VEL_W-1:0]  velo_ff;
   logic                     flago_ff;

   always_comb begin
      diff_in  = {accel[ACCEL_W-1], accel} - {bias[ACCEL_W-1], bias};
      diff_ext = {diff_in[DIFF_W-1], diff_in};
      thr_ext  = {{(DIFF_W+1-THR_W){1'b0}}, thr};
      // open window: -thr < accel - bias < thr
      win_in   = (diff_ext < thr_ext) && (diff_ext > -thr_ext);
   end

   always_ff @(posedge clock) begin
      if (ctrl.s1_load) begin
         diff_ff <= diff_in;
         win_ff  <= win_in;
      end
   end

   always_comb begin
      vsum_wide = {vel_ff[VEL_W-1], vel_ff}
                + {{(VEL_W+1-DIFF_W){diff_ff[DIFF_W-1]}}, diff_ff};
      if (vsum_wide[VEL_W] != vsum_wide[VEL_W-1]) begin
         vsum = vsum_wide[VEL_W] ? {1'b1, {(VEL_W-1){1'b0}}} : {1'b0, {(VEL_W-1){1'b1}}};
      end else begin
         vsum = vsum_wide[VEL_W-1:0];
      end
      if (win_ff) begin
         run_in = (run_ff == RUN_MAX) ? run_ff : run_ff + 1'b1;
      end else begin
         run_in = '0;
      end
      clear  = (run_in >= cnt);
      vel_in = clear ? '0 : vsum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vel_ff <= '0;
         run_ff <= '0;
      end else if (ctrl.s2_load) begin
         vel_ff <= vel_in;
         run_ff <= run_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.s2_load) begin
         vout_ff  <= vel_in;
         vsum_ff  <= vsum;
         flag2_ff <= clear;
      end
   end

   // position takes the velocity before the zero-velocity clear
   always_comb begin
      psum   = {{(SUM_W-POS_W){pos_ff[POS_W-1]}}, pos_ff}
             + {{(SUM_W-VEL_W){vsum_ff[VEL_W-1]}}, vsum_ff};
      hi_lim = {{(SUM_W-POS_W+1){1'b0}}, {(POS_W-1){1'b1}}};
      lo_lim = ~hi_lim;
      if (psum > hi_lim) begin
         pos_in = hi_lim[POS_W-1:0];
      end else if (psum < lo_lim) begin
         pos_in = lo_lim[POS_W-1:0];
      end else begin
         pos_in = psum[POS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (ctrl.s3_load) begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.s3_load) begin
         velo_ff  <= vout_ff;
         flago_ff <= flag2_ff;
      end
   end

   assign vel  = velo_ff;
   assign pos  = pos_ff;
   assign flag = flago_ff;

endmodule

FILE: sv/drzv_ctrl.sv
// pipeline valid tracking and per-stage load enables for the lanes
// depends on drzv_pkg
module drzv_ctrl import drzv_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output pipe_ctrl_type ctrl
);

   logic v1_ff, v2_ff, v3_ff;
   logic v1_in, v2_in, v3_in;
   logic rdy1, rdy2, rdy3;

   // a stage moves when it is empty or the stage after it moves
   always_comb begin
      rdy3  = !v3_ff || rsp_ready;
      rdy2  = !v2_ff || rdy3;
      rdy1  = !v1_ff || rdy2;
      v1_in = rdy1 ? req_valid : v1_ff;
      v2_in = rdy2 ? v1_ff : v2_ff;
      v3_in = rdy3 ? v2_ff : v3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   assign req_ready     = rdy1;
   assign rsp_valid     = v3_ff;
   assign ctrl.s1_load  = req_valid && rdy1;
   assign ctrl.s2_load  = v1_ff && rdy2;
   assign ctrl.s3_load  = v2_ff && rdy3;
   assign ctrl.s2_valid = v2_ff;

endmodule

FILE: sv/drzv_csr.sv
// configuration registers behind the apb-style port
// depends on drzv_pkg
module drzv_csr import drzv_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready,
   output cfg_type           cfg
);

   cfg_type       cfg_in, cfg_ff;
   csr_index_type idx;
   logic          wr_en;

   assign idx   = csr_index_type'(csr_paddr[CSR_AW-1:2]);
   assign wr_en = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_BIAS_X:          cfg_in.bias_x          = csr_pwdata[ACCEL_W-1:0];
            REG_BIAS_Y:          cfg_in.bias_y          = csr_pwdata[ACCEL_W-1:0];
            REG_BIAS_Z:          cfg_in.bias_z          = csr_pwdata[ACCEL_W-1:0];
            REG_STILL_THRESHOLD: cfg_in.still_threshold = csr_pwdata[THR_W-1:0];
            REG_STILL_COUNT:     cfg_in.still_count     = csr_pwdata[CNT_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bias_x          <= '0;
         cfg_ff.bias_y          <= '0;
         cfg_ff.bias_z          <= '0;
         cfg_ff.still_threshold <= THR_RESET;
         cfg_ff.still_count     <= CNT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (idx)
         REG_BIAS_X:          csr_prdata = {{(CSR_DW-ACCEL_W){cfg_ff.bias_x[ACCEL_W-1]}},
                                            cfg_ff.bias_x};
         REG_BIAS_Y:          csr_prdata = {{(CSR_DW-ACCEL_W){cfg_ff.bias_y[ACCEL_W-1]}},
                                            cfg_ff.bias_y};
         REG_BIAS_Z:          csr_prdata = {{(CSR_DW-ACCEL_W){cfg_ff.bias_z[ACCEL_W-1]}},
                                            cfg_ff.bias_z};
         REG_STILL_THRESHOLD: csr_prdata = {{(CSR_DW-THR_W){1'b0}}, cfg_ff.still_threshold};
         REG_STILL_COUNT:     csr_prdata = {{(CSR_DW-CNT_W){1'b0}}, cfg_ff.still_count};
         default:             csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

endmodule

FILE: sv/accel_dead_reckoning_zero_velocity.sv
// top level: three axis lanes, pipeline control, config registers, result merge
// depends on drzv_pkg, drzv_lane, drzv_ctrl, drzv_csr and the macros header
//
//   port group   dir   handshake              carries
//   req_         in    req_valid/req_ready    one accel sample, three axes
//   rsp_         out   rsp_valid/rsp_ready    velocities, positions, still flags
//   csr_         in    apb psel/penable       bias, threshold, still count
//
// one item per cycle sustained while rsp_ready stays high; an accepted sample passes
// through the lane stages (bias/window, velocity and run counter, position).
// synchronous reset clears accumulators and run counters and loads register
// defaults; no clearing pass. a stalled result holds the last stage; earlier
// stages keep filling and req_ready drops only once all three are full.
`include "accel_dead_reckoning_zero_velocity_macros.svh"

module accel_dead_reckoning_zero_velocity import drzv_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_payload_type   req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_payload_type   rsp_payload,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   cfg_type                 cfg;
   pipe_ctrl_type           ctrl;
   logic signed [VEL_W-1:0] vel_x, vel_y, vel_z;
   logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
   logic                    flag_x, flag_y, flag_z;

   drzv_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   drzv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ctrl      (ctrl)
   );

   drzv_lane u_lane_x (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .accel (req_payload.accel_x),
      .bias  (cfg.bias_x),
      .thr   (cfg.still_threshold),
      .cnt   (cfg.still_count),
      .vel   (vel_x),
      .pos   (pos_x),
      .flag  (flag_x)
   );

   drzv_lane u_lane_y (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .accel (req_payload.accel_y),
      .bias  (cfg.bias_y),
      .thr   (cfg.still_threshold),
      .cnt   (cfg.still_count),
      .vel   (vel_y),
      .pos   (pos_y),
      .flag  (flag_y)
   );

   drzv_lane u_lane_z (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .accel (req_payload.accel_z),
      .bias  (cfg.bias_z),
      .thr   (cfg.still_threshold),
      .cnt   (cfg.still_count),
      .vel   (vel_z),
      .pos   (pos_z),
      .flag  (flag_z)
   );

   // merge lane results into one item
   always_comb begin
      rsp_payload.vel_x       = vel_x;
      rsp_payload.vel_y       = vel_y;
      rsp_payload.vel_z       = vel_z;
      rsp_payload.pos_x       = pos_x;
      rsp_payload.pos_y       = pos_y;
      rsp_payload.pos_z       = pos_z;
      rsp_payload.still_flags = {flag_z, flag_y, flag_x};
   end

   `DRZV_ASSERT_NOW(a_flag_x_zero_vel, clock, reset, rsp_valid && rsp_payload.still_flags[0], rsp_payload.vel_x == '0, "x flagged but velocity not cleared")
   `DRZV_ASSERT_NOW(a_flag_z_zero_vel, clock, reset, rsp_valid && rsp_payload.still_flags[2], rsp_payload.vel_z == '0, "z flagged but velocity not cleared")
   `DRZV_ASSERT_NOW(a_ready_when_drained, clock, reset, !rsp_valid, req_ready, "input stalled with empty output stage")
   `DRZV_ASSERT_NEXT(a_output_drains, clock, reset, rsp_valid && rsp_ready && !ctrl.s2_valid, !rsp_valid, "result appeared from empty stage")

endmodule
